FILE: rtl/mtrdl_pkg.sv
// shared types and constants for the multitap reversible delay line
// no dependencies
`timescale 1ns / 1ps

package mtrdl_pkg;

   // magnitude width of a gain result
   localparam int unsigned QW = 16;

   // register indexes of the configuration port
   localparam logic CSR_ACTIVE_TAPS = 1'b0;
   localparam logic CSR_REVERSE_MODE = 1'b1;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_SET_DELAY,
      REQ_LATCH_START,
      REQ_LATCH_RELEASE
   } req_kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_T_CHECK,
      ST_T_CUR,
      ST_T_PREV,
      ST_T_MAC,
      ST_T_REV,
      ST_T_LAT,
      ST_T_EMIT,
      ST_T_ADV,
      ST_W_START,
      ST_W_SCALE,
      ST_W_COPY,
      ST_W_WRITE,
      ST_W_DONE,
      ST_D_START,
      ST_D_WAIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_SET_DELAY,
      OP_LATCH_START,
      OP_LATCH_RELEASE,
      OP_RD_CUR,
      OP_TAKE_CUR,
      OP_MUL_PREV,
      OP_MAC_CUR,
      OP_MUL,
      OP_DIV_START,
      OP_DIV_TAKE,
      OP_EMIT,
      OP_TAP_ADV,
      OP_LOAD_IN,
      OP_RD_SRC,
      OP_WR_COPY,
      OP_WR_S,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      CNT_REV,
      CNT_LATCH_RD,
      CNT_WRITE
   } cnt_sel_type;

   typedef enum logic [1:0] {
      WM_NORMAL,
      WM_FIRST,
      WM_LOOP
   } wr_mode_type;

   typedef struct packed {
      op_type      op;
      cnt_sel_type cnt_sel;
   } cmd_type;

   typedef struct packed {
      logic         clear_done;
      logic         div_done;
      logic         blend_need;
      logic         rev_need;
      logic         latch_rd_need;
      logic         wr_scale_need;
      wr_mode_type  wr_mode;
      logic         tap_active;
      logic         tap_last;
      logic         out_free;
      req_kind_type kind;
   } sts_type;

endpackage

FILE: rtl/mtrdl_if.sv
// request and result channel interfaces of the delay line
// no dependencies
`timescale 1ns / 1ps

interface mtrdl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [15:0] sample_in;
   logic [1:0]         tap_select;
   logic [13:0]        delay_length;
   logic [13:0]        latch_length;

   modport source (
      output valid, req_type, sample_in, tap_select, delay_length, latch_length,
      input ready
   );
   modport sink (
      input valid, req_type, sample_in, tap_select, delay_length, latch_length,
      output ready
   );
endinterface

interface mtrdl_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         tap_number;
   logic signed [15:0] sample_out;
   logic               last_of_run;

   modport source (
      output valid, tap_number, sample_out, last_of_run,
      input ready
   );
   modport sink (
      input valid, tap_number, sample_out, last_of_run,
      output ready
   );
endinterface

FILE: rtl/mtrdl_div.sv
// two-stage divider by the constant FADE using a reciprocal multiply
// truncates toward zero; uses mtrdl_pkg
`timescale 1ns / 1ps

module mtrdl_div #(
   parameter int unsigned FADE = 64,
   parameter int unsigned PW = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [PW-1:0]            dividend,
   output logic                            busy,
   output logic signed [mtrdl_pkg::QW-1:0] quotient
);
   import mtrdl_pkg::*;

   // magnitude width, product shift and reciprocal width
   localparam int unsigned MW = PW - 1;
   localparam int unsigned SH = MW + $clog2(FADE);
   localparam int unsigned RW = MW + 2;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(FADE) - 64'd1) / 64'(FADE);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

   logic                mul_ff, mul_in;
   logic                neg_ff, neg_in;
   logic [MW-1:0]       mag_ff, mag_in;
   logic [MW+RW-1:0]    prod_ff, prod_in;
   logic [PW-1:0]       abs_v;
   logic [QW-1:0]       q;

   always_comb begin
      mul_in  = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      prod_in = prod_ff;
      abs_v   = dividend[PW-1] ? (~dividend + PW'(1)) : dividend;
      if (start) begin
         mul_in = 1'b1;
         neg_in = dividend[PW-1];
         mag_in = abs_v[MW-1:0];
      end else if (mul_ff) begin
         prod_in = (MW+RW)'(mag_ff) * (MW+RW)'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 1'b0;
      end else begin
         mul_ff <= mul_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
   end

   assign q        = prod_ff[SH +: QW];
   assign busy     = mul_ff;
   assign quotient = neg_ff ? $signed(~q + QW'(1)) : $signed(q);

endmodule

FILE: rtl/mtrdl_dp.sv
// datapath: sample store, tap and latch state, shared multiplier and divider
// uses mtrdl_pkg and mtrdl_div
`timescale 1ns / 1ps

module mtrdl_dp #(
   parameter int unsigned DEPTH = 16384,
   parameter int unsigned TAPS = 4,
   parameter int unsigned FADE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mtrdl_pkg::cmd_type     cmd,
   output mtrdl_pkg::sts_type     sts,
   input  logic [1:0]             req_type,
   input  logic signed [15:0]     sample_in,
   input  logic [1:0]             tap_select,
   input  logic [13:0]            delay_length,
   input  logic [13:0]            latch_length,
   input  logic [2:0]             active_taps,
   input  logic                   reverse_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             tap_number,
   output logic signed [15:0]     sample_out,
   output logic                   last_of_run
);
   import mtrdl_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned TW = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int unsigned CW = $clog2(FADE + 1);
   localparam int unsigned PW = QW + CW + 2;
   localparam int unsigned DW = ((AW > CW) ? AW : CW) + 2;
   localparam logic signed [DW-1:0] FADE_S = DW'(FADE);

   function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[AW]) begin
         d = d + (AW+1)'(DEPTH);
      end
      return d[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] a);
      return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
   endfunction

   function automatic logic [AW-1:0] dec_mod(input logic [AW-1:0] a);
      return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
   endfunction

   function automatic logic [AW-1:0] clamp_len(input logic [13:0] v);
      return (int'(v) > int'(DEPTH) - 1) ? AW'(DEPTH - 1) : AW'(v);
   endfunction

   function automatic logic [AW-1:0] loop_limit(input logic [AW-1:0] d);
      logic [AW:0] l;
      l = {d, 1'b0};
      return (l < (AW+1)'(DEPTH - 1)) ? AW'(l) : AW'(DEPTH - 1);
   endfunction

   function automatic logic [AW-1:0] step_back(input logic [AW-1:0] pos,
                                               input logic [AW-1:0] wp,
                                               input logic [AW-1:0] lim);
      logic [AW-1:0] pm;
      pm = dec_mod(pos);
      return (sub_mod(wp, pm) >= lim) ? wp : pm;
   endfunction

   function automatic logic [CW-1:0] clip_cnt(input logic signed [DW-1:0] v);
      return v[DW-1] ? '0 : CW'(v);
   endfunction

   // request fields
   req_kind_type       kind_ff, kind_in;
   logic signed [15:0] smp_ff, smp_in;
   logic [1:0]         sel_ff, sel_in;
   logic [13:0]        dly_ff, dly_in;
   logic [13:0]        llen_ff, llen_in;

   // delay line state
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff [TAPS];
   logic [AW-1:0] rp_in [TAPS];
   logic [AW-1:0] pp_ff [TAPS];
   logic [AW-1:0] pp_in [TAPS];
   logic [CW-1:0] fp_ff [TAPS];
   logic [CW-1:0] fp_in [TAPS];
   logic [AW-1:0] td_ff [TAPS];
   logic [AW-1:0] td_in [TAPS];
   logic          lat_act_ff, lat_act_in;
   logic          lat_first_ff, lat_first_in;
   logic [AW:0]   lat_cnt_ff, lat_cnt_in;
   logic [AW-1:0] lat_len_ff, lat_len_in;
   logic          fip_ff, fip_in;
   logic [CW-1:0] fic_ff, fic_in;

   // working registers
   logic [TW-1:0]        t_ff, t_in;
   logic signed [15:0]   s_ff, s_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [15:0]          mem_q_ff;

   // result register
   logic               ov_ff, ov_in;
   logic [1:0]         otap_ff, otap_in;
   logic signed [15:0] osmp_ff, osmp_in;
   logic               olast_ff, olast_in;

   logic [15:0] sample_store [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;
   logic          mem_re;
   logic [AW-1:0] mem_ra;

   logic [3:0]           ntap;
   logic [AW-1:0]        rp_t, pp_t, td_t, lim_t, dist_t;
   logic [CW-1:0]        fp_t;
   logic signed [DW-1:0] remain_t, left_l;
   logic                 tap_active, rev_need, latch_rd_need, cnt_small;
   logic [CW-1:0]        rev_cnt, lrd_cnt, wr_cnt, cnt_mux;
   wr_mode_type          wr_mode;
   logic                 wr_scale_need;
   logic signed [15:0]   mul_a;
   logic signed [CW:0]   mul_b;
   logic signed [PW-1:0] prod;
   logic                 div_busy;
   logic signed [QW-1:0] div_q;
   logic [AW-1:0]        rn, pn, dly_c;
   logic [CW:0]          f1;
   logic [AW:0]          cnt1;
   logic [CW-1:0]        fic1;

   mtrdl_div #(.FADE(FADE), .PW(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV_START),
      .dividend (acc_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // per tap and latch status
   always_comb begin
      ntap       = (int'(active_taps) > int'(TAPS)) ? 4'(TAPS) : 4'(active_taps);
      tap_active = 4'(t_ff) < ntap;
      rp_t       = rp_ff[t_ff];
      pp_t       = pp_ff[t_ff];
      fp_t       = fp_ff[t_ff];
      td_t       = td_ff[t_ff];
      lim_t      = loop_limit(td_t);
      dist_t     = sub_mod(wp_ff, rp_t);
      remain_t   = $signed(DW'(lim_t)) - $signed(DW'(dist_t));
      rev_need   = reverse_mode && ((remain_t < FADE_S) || (DW'(dist_t) < DW'(FADE)));
      rev_cnt    = (remain_t < FADE_S) ? clip_cnt(remain_t) : CW'(dist_t);
      left_l     = $signed(DW'(lat_len_ff)) - $signed(DW'(lat_cnt_ff));
      latch_rd_need = lat_first_ff && (left_l < FADE_S);
      lrd_cnt    = clip_cnt(left_l);
      cnt_small  = DW'(lat_cnt_ff) < DW'(FADE);
      if (lat_act_ff && lat_first_ff) begin
         wr_mode       = WM_FIRST;
         wr_scale_need = cnt_small || (left_l < FADE_S);
         wr_cnt        = cnt_small ? CW'(lat_cnt_ff) : clip_cnt(left_l);
      end else if (lat_act_ff) begin
         wr_mode       = WM_LOOP;
         wr_scale_need = 1'b0;
         wr_cnt        = fic_ff;
      end else begin
         wr_mode       = WM_NORMAL;
         wr_scale_need = fip_ff;
         wr_cnt        = fic_ff;
      end
      case (cmd.cnt_sel)
         CNT_REV:      cnt_mux = rev_cnt;
         CNT_LATCH_RD: cnt_mux = lrd_cnt;
         CNT_WRITE:    cnt_mux = wr_cnt;
         default:      cnt_mux = '0;
      endcase
   end

   always_comb begin
      sts.clear_done    = clr_ff == AW'(DEPTH - 1);
      sts.div_done      = !div_busy;
      sts.blend_need    = (rp_t != pp_t) && (fp_t < CW'(FADE));
      sts.rev_need      = rev_need;
      sts.latch_rd_need = latch_rd_need;
      sts.wr_scale_need = wr_scale_need;
      sts.wr_mode       = wr_mode;
      sts.tap_active    = tap_active;
      sts.tap_last      = t_ff == TW'(TAPS - 1);
      sts.out_free      = !ov_ff || rsp_ready;
      sts.kind          = kind_ff;
   end

   // shared multiplier
   always_comb begin
      case (cmd.op)
         OP_MUL_PREV: begin
            mul_a = $signed(mem_q_ff);
            mul_b = $signed({1'b0, CW'(FADE) - fp_t});
         end
         OP_MAC_CUR: begin
            mul_a = s_ff;
            mul_b = $signed({1'b0, fp_t});
         end
         default: begin
            mul_a = s_ff;
            mul_b = $signed({1'b0, cnt_mux});
         end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      kind_in      = kind_ff;
      smp_in       = smp_ff;
      sel_in       = sel_ff;
      dly_in       = dly_ff;
      llen_in      = llen_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      pp_in        = pp_ff;
      fp_in        = fp_ff;
      td_in        = td_ff;
      lat_act_in   = lat_act_ff;
      lat_first_in = lat_first_ff;
      lat_cnt_in   = lat_cnt_ff;
      lat_len_in   = lat_len_ff;
      fip_in       = fip_ff;
      fic_in       = fic_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      clr_in       = clr_ff;
      ov_in        = ov_ff && !rsp_ready;
      otap_in      = otap_ff;
      osmp_in      = osmp_ff;
      olast_in     = olast_ff;
      mem_we       = 1'b0;
      mem_wa       = wp_ff;
      mem_wd       = 16'(s_ff);
      mem_re       = 1'b0;
      mem_ra       = rp_t;
      dly_c        = clamp_len(dly_ff);
      rn           = rp_t;
      pn           = pp_t;
      f1           = {1'b0, fp_t} + (CW+1)'(1);
      cnt1         = lat_cnt_ff + (AW+1)'(1);
      fic1         = fic_ff + CW'(1);
      case (cmd.op)
         OP_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AW'(1);
         end
         OP_ACCEPT: begin
            kind_in = req_kind_type'(req_type);
            smp_in  = sample_in;
            sel_in  = tap_select;
            dly_in  = delay_length;
            llen_in = latch_length;
            t_in    = '0;
         end
         OP_SET_DELAY: begin
            if (int'(sel_ff) < int'(TAPS)) begin
               td_in[TW'(sel_ff)] = dly_c;
               pp_in[TW'(sel_ff)] = rp_ff[TW'(sel_ff)];
               rp_in[TW'(sel_ff)] = sub_mod(wp_ff, dly_c);
               fp_in[TW'(sel_ff)] = '0;
            end
         end
         OP_LATCH_START: begin
            lat_act_in   = 1'b1;
            lat_first_in = 1'b1;
            lat_cnt_in   = '0;
            lat_len_in   = clamp_len(llen_ff);
         end
         OP_LATCH_RELEASE: begin
            if (lat_first_ff) begin
               fip_in = 1'b1;
               fic_in = '0;
            end
            lat_act_in   = 1'b0;
            lat_first_in = 1'b0;
         end
         OP_RD_CUR: begin
            mem_re = 1'b1;
            mem_ra = rp_t;
         end
         OP_TAKE_CUR: begin
            s_in   = $signed(mem_q_ff);
            mem_re = 1'b1;
            mem_ra = pp_t;
         end
         OP_MUL_PREV, OP_MUL: begin
            acc_in = prod;
         end
         OP_MAC_CUR: begin
            acc_in = acc_ff + prod;
         end
         OP_DIV_TAKE: begin
            s_in = div_q;
         end
         OP_EMIT: begin
            ov_in    = 1'b1;
            otap_in  = 2'(t_ff);
            osmp_in  = s_ff;
            olast_in = (4'(t_ff) + 4'd1) == ntap;
         end
         OP_TAP_ADV: begin
            if (tap_active) begin
               if (reverse_mode) begin
                  rn = step_back(rp_t, wp_ff, lim_t);
                  pn = step_back(pp_t, wp_ff, lim_t);
               end else begin
                  rn = inc_mod(rp_t);
                  pn = inc_mod(pp_t);
               end
            end
            if ((rn != pn) && (fp_t < CW'(FADE))) begin
               if (f1 >= (CW+1)'(FADE)) begin
                  pn = rn;
                  fp_in[t_ff] = '0;
               end else begin
                  fp_in[t_ff] = CW'(f1);
               end
            end
            rp_in[t_ff] = rn;
            pp_in[t_ff] = pn;
            t_in = (t_ff == TW'(TAPS - 1)) ? '0 : t_ff + TW'(1);
         end
         OP_LOAD_IN: begin
            s_in = smp_ff;
         end
         OP_RD_SRC: begin
            mem_re = 1'b1;
            mem_ra = sub_mod(wp_ff, lat_len_ff);
         end
         OP_WR_COPY: begin
            mem_we = 1'b1;
            mem_wd = mem_q_ff;
         end
         OP_WR_S: begin
            mem_we = 1'b1;
         end
         OP_FINISH: begin
            case (wr_mode)
               WM_FIRST: begin
                  if (cnt1 > {1'b0, lat_len_ff}) begin
                     lat_first_in = 1'b0;
                     fip_in       = 1'b1;
                     lat_cnt_in   = '0;
                  end else begin
                     lat_cnt_in = cnt1;
                  end
               end
               WM_NORMAL: begin
                  if (fip_ff) begin
                     if ({1'b0, fic1} >= (CW+1)'(FADE)) begin
                        fic_in = '0;
                        fip_in = 1'b0;
                     end else begin
                        fic_in = fic1;
                     end
                  end
               end
               default: begin
               end
            endcase
            wp_in = inc_mod(wp_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= sample_store[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         lat_act_ff   <= 1'b0;
         lat_first_ff <= 1'b0;
         lat_cnt_ff   <= '0;
         lat_len_ff   <= '0;
         fip_ff       <= 1'b0;
         fic_ff       <= '0;
         t_ff         <= '0;
         clr_ff       <= '0;
         ov_ff        <= 1'b0;
         kind_ff      <= REQ_TICK;
         for (int i = 0; i < int'(TAPS); i++) begin
            rp_ff[i] <= '0;
            pp_ff[i] <= '0;
            fp_ff[i] <= '0;
            td_ff[i] <= '0;
         end
      end else begin
         wp_ff        <= wp_in;
         lat_act_ff   <= lat_act_in;
         lat_first_ff <= lat_first_in;
         lat_cnt_ff   <= lat_cnt_in;
         lat_len_ff   <= lat_len_in;
         fip_ff       <= fip_in;
         fic_ff       <= fic_in;
         t_ff         <= t_in;
         clr_ff       <= clr_in;
         ov_ff        <= ov_in;
         kind_ff      <= kind_in;
         rp_ff        <= rp_in;
         pp_ff        <= pp_in;
         fp_ff        <= fp_in;
         td_ff        <= td_in;
      end
      smp_ff   <= smp_in;
      sel_ff   <= sel_in;
      dly_ff   <= dly_in;
      llen_ff  <= llen_in;
      s_ff     <= s_in;
      acc_ff   <= acc_in;
      otap_ff  <= otap_in;
      osmp_ff  <= osmp_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid   = ov_ff;
   assign tap_number  = otap_ff;
   assign sample_out  = osmp_ff;
   assign last_of_run = olast_ff;

   a_wp_moves_on_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_FINISH) |=> $stable(wp_ff))
      else $error("write position moved outside the finish step");

   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |=> ov_ff)
      else $error("emitted item did not reach the output register");

   a_fade_in_range: assert property (@(posedge clock) disable iff (reset)
      fp_ff[0] < CW'(FADE))
      else $error("crossfade progress out of range");

   a_div_take_when_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_TAKE) |-> !div_busy)
      else $error("quotient taken while divider busy");

endmodule

FILE: rtl/mtrdl_ctrl.sv
// controller state machine: clearing pass, request dispatch, tap loop, write
// uses mtrdl_pkg
`timescale 1ns / 1ps

module mtrdl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   output mtrdl_pkg::cmd_type cmd,
   input  mtrdl_pkg::sts_type sts
);
   import mtrdl_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (in_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = (sts.kind == REQ_TICK) ? ST_T_CHECK : ST_IDLE;
         end
         ST_T_CHECK: begin
            state_in = sts.tap_active ? ST_T_CUR : ST_T_ADV;
         end
         ST_T_CUR: begin
            state_in = sts.blend_need ? ST_T_PREV : ST_T_REV;
         end
         ST_T_PREV: begin
            state_in = ST_T_MAC;
         end
         ST_T_MAC: begin
            state_in = ST_D_START;
            ret_in   = ST_T_REV;
         end
         ST_T_REV: begin
            if (sts.rev_need) begin
               state_in = ST_D_START;
               ret_in   = ST_T_LAT;
            end else begin
               state_in = ST_T_LAT;
            end
         end
         ST_T_LAT: begin
            if (sts.latch_rd_need) begin
               state_in = ST_D_START;
               ret_in   = ST_T_EMIT;
            end else begin
               state_in = ST_T_EMIT;
            end
         end
         ST_T_EMIT: begin
            if (sts.out_free) state_in = ST_T_ADV;
         end
         ST_T_ADV: begin
            state_in = sts.tap_last ? ST_W_START : ST_T_CHECK;
         end
         ST_W_START: begin
            state_in = (sts.wr_mode == WM_LOOP) ? ST_W_COPY : ST_W_SCALE;
         end
         ST_W_SCALE: begin
            if (sts.wr_scale_need) begin
               state_in = ST_D_START;
               ret_in   = ST_W_WRITE;
            end else begin
               state_in = ST_W_WRITE;
            end
         end
         ST_W_COPY: begin
            state_in = ST_W_DONE;
         end
         ST_W_WRITE: begin
            state_in = ST_W_DONE;
         end
         ST_W_DONE: begin
            state_in = ST_IDLE;
         end
         ST_D_START: begin
            state_in = ST_D_WAIT;
         end
         ST_D_WAIT: begin
            if (sts.div_done) state_in = ret_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.cnt_sel = CNT_REV;
      in_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
         end
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) cmd.op = OP_ACCEPT;
         end
         ST_DISPATCH: begin
            case (sts.kind)
               REQ_SET_DELAY:     cmd.op = OP_SET_DELAY;
               REQ_LATCH_START:   cmd.op = OP_LATCH_START;
               REQ_LATCH_RELEASE: cmd.op = OP_LATCH_RELEASE;
               default:           cmd.op = OP_NONE;
            endcase
         end
         ST_T_CHECK: begin
            if (sts.tap_active) cmd.op = OP_RD_CUR;
         end
         ST_T_CUR: begin
            cmd.op = OP_TAKE_CUR;
         end
         ST_T_PREV: begin
            cmd.op = OP_MUL_PREV;
         end
         ST_T_MAC: begin
            cmd.op = OP_MAC_CUR;
         end
         ST_T_REV: begin
            if (sts.rev_need) begin
               cmd.op      = OP_MUL;
               cmd.cnt_sel = CNT_REV;
            end
         end
         ST_T_LAT: begin
            if (sts.latch_rd_need) begin
               cmd.op      = OP_MUL;
               cmd.cnt_sel = CNT_LATCH_RD;
            end
         end
         ST_T_EMIT: begin
            if (sts.out_free) cmd.op = OP_EMIT;
         end
         ST_T_ADV: begin
            cmd.op = OP_TAP_ADV;
         end
         ST_W_START: begin
            cmd.op = (sts.wr_mode == WM_LOOP) ? OP_RD_SRC : OP_LOAD_IN;
         end
         ST_W_SCALE: begin
            if (sts.wr_scale_need) begin
               cmd.op      = OP_MUL;
               cmd.cnt_sel = CNT_WRITE;
            end
         end
         ST_W_COPY: begin
            cmd.op = OP_WR_COPY;
         end
         ST_W_WRITE: begin
            cmd.op = OP_WR_S;
         end
         ST_W_DONE: begin
            cmd.op = OP_FINISH;
         end
         ST_D_START: begin
            cmd.op = OP_DIV_START;
         end
         ST_D_WAIT: begin
            if (sts.div_done) cmd.op = OP_DIV_TAKE;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

FILE: rtl/multitap_reversible_delay_line_top.sv
// Multi-tap audio delay line with crossfaded tap moves, reverse play and a
// latched loop. After reset the sample store is zeroed in a pass over its
// DEPTH entries, during which no request is taken; configuration writes are
// taken at any time. Requests are handled one at a time. A sample tick applies
// a gain for each crossfade, reverse loop edge, latch tail and input fade, each
// gain being a division by FADE in the shared two-stage reciprocal multiplier;
// a result may also wait for the output register to empty, and the single read
// port of the store reads the taps one after another. Results wait in an
// output register, so the next request is taken while the last result is
// still pending.
// uses mtrdl_pkg, mtrdl_if, mtrdl_ctrl and mtrdl_dp
`timescale 1ns / 1ps

module multitap_reversible_delay_line_top #(
   parameter int unsigned DEPTH = 16384,
   parameter int unsigned TAPS = 4,
   parameter int unsigned FADE = 64
) (
   input  logic        clock,
   input  logic        reset,
   mtrdl_req_if.sink   req,
   mtrdl_rsp_if.source rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mtrdl_pkg::*;

   logic [2:0] active_taps_ff, active_taps_in;
   logic       reverse_mode_ff, reverse_mode_in;
   logic       csr_wr;
   cmd_type    cmd;
   sts_type    sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      active_taps_in  = active_taps_ff;
      reverse_mode_in = reverse_mode_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_ACTIVE_TAPS:  active_taps_in  = pwdata[2:0];
            CSR_REVERSE_MODE: reverse_mode_in = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_ACTIVE_TAPS:  prdata = 32'(active_taps_ff);
         CSR_REVERSE_MODE: prdata = 32'(reverse_mode_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_taps_ff  <= 3'd1;
         reverse_mode_ff <= 1'b0;
      end else begin
         active_taps_ff  <= active_taps_in;
         reverse_mode_ff <= reverse_mode_in;
      end
   end

   mtrdl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   mtrdl_dp #(.DEPTH(DEPTH), .TAPS(TAPS), .FADE(FADE)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_type     (req.req_type),
      .sample_in    (req.sample_in),
      .tap_select   (req.tap_select),
      .delay_length (req.delay_length),
      .latch_length (req.latch_length),
      .active_taps  (active_taps_ff),
      .reverse_mode (reverse_mode_ff),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .tap_number   (rsp.tap_number),
      .sample_out   (rsp.sample_out),
      .last_of_run  (rsp.last_of_run)
   );

endmodule
